FILE: sv/fxalu_pkg.sv
package fxalu_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned NumW     = 34 + FracBits;
  localparam int unsigned DivW     = NumW - 1;
  localparam int unsigned DvsW     = 33;
  localparam int unsigned RemW     = 33;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_GT   = 4'd4,
    OP_LT   = 4'd5,
    OP_GE   = 4'd6,
    OP_LE   = 4'd7,
    OP_EQ   = 4'd8,
    OP_NE   = 4'd9,
    OP_MIN  = 4'd10,
    OP_MAX  = 4'd11,
    OP_INC  = 4'd12,
    OP_DEC  = 4'd13,
    OP_TOI  = 4'd14,
    OP_FROM = 4'd15
  } op_e;

  typedef struct packed {
    op_e              func;
    logic [31:0]      res;
    logic             cmp;
    logic             dz;
    logic             qneg;
    logic [DivW-1:0]  dvd;
    logic [RemW-1:0]  rem;
    logic [DvsW-1:0]  dvs;
    logic [31:0]      quo;
  } cell_t;

endpackage

FILE: sv/fxalu_if.sv
interface fxalu_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         func;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, func, operand_a, operand_b, input ready);
  modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fxalu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic               divide_by_zero;

  modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
  modport sink   (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

FILE: sv/fxalu_front.sv
module fxalu_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [3:0]             func_i,
  input  logic signed [31:0]     a_i,
  input  logic signed [31:0]     b_i,
  output logic                   valid_o,
  output fxalu_pkg::cell_t       cell_o
);

  localparam int unsigned NumW = fxalu_pkg::NumW;
  localparam int unsigned DivW = fxalu_pkg::DivW;
  localparam int unsigned DvsW = fxalu_pkg::DvsW;
  localparam int unsigned F    = fxalu_pkg::FracBits;

  fxalu_pkg::op_e       op;
  logic [31:0]          res_d;
  logic                 cmp_d;
  logic                 dz_d;
  logic signed [NumW-1:0] ax, bx, n, nn, dd, num, m;
  logic signed [63:0]   prod_d;

  logic                 va_q;
  fxalu_pkg::op_e       op_q;
  logic [31:0]          res_q;
  logic                 cmp_q, dz_q, qneg_q;
  logic signed [63:0]   prod_q;
  logic [DivW-1:0]      dvd_q;
  logic [DvsW-1:0]      dvs_q;
  logic signed [63:0]   rnd;

  always_comb begin
    op    = fxalu_pkg::op_e'(func_i);
    res_d = '0;
    cmp_d = 1'b0;
    dz_d  = 1'b0;
    case (op)
      fxalu_pkg::OP_ADD:  res_d = a_i + b_i;
      fxalu_pkg::OP_SUB:  res_d = a_i - b_i;
      fxalu_pkg::OP_DIV:  dz_d  = (b_i == 32'sd0);
      fxalu_pkg::OP_GT:   cmp_d = (a_i > b_i);
      fxalu_pkg::OP_LT:   cmp_d = (a_i < b_i);
      fxalu_pkg::OP_GE:   cmp_d = (a_i >= b_i);
      fxalu_pkg::OP_LE:   cmp_d = (a_i <= b_i);
      fxalu_pkg::OP_EQ:   cmp_d = (a_i == b_i);
      fxalu_pkg::OP_NE:   cmp_d = (a_i != b_i);
      fxalu_pkg::OP_MIN:  res_d = (a_i < b_i) ? a_i : b_i;
      fxalu_pkg::OP_MAX:  res_d = (a_i > b_i) ? a_i : b_i;
      fxalu_pkg::OP_INC:  res_d = a_i + 32'sd1;
      fxalu_pkg::OP_DEC:  res_d = a_i - 32'sd1;
      fxalu_pkg::OP_TOI:  res_d = a_i >>> F;
      fxalu_pkg::OP_FROM: res_d = a_i <<< F;
      default:            res_d = '0;
    endcase
  end

  always_comb begin
    prod_d = 64'(a_i) * 64'(b_i);
    ax  = {{(NumW-32){a_i[31]}}, a_i};
    bx  = {{(NumW-32){b_i[31]}}, b_i};
    n   = ax <<< F;
    nn  = b_i[31] ? -n : n;
    dd  = b_i[31] ? -bx : bx;
    num = (nn <<< 1) + dd - NumW'(1);
    m   = num[NumW-1] ? ~num : num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      va_q    <= valid_i;
      valid_o <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q   <= op;
      res_q  <= res_d;
      cmp_q  <= cmp_d;
      dz_q   <= dz_d;
      qneg_q <= num[NumW-1];
      prod_q <= prod_d;
      dvd_q  <= m[DivW-1:0];
      dvs_q  <= {dd[DvsW-2:0], 1'b0};
    end
  end

  assign rnd = (prod_q + 64'sd1 * ((64'sd1 <<< (F - 1)) - 64'sd1)) >>> F;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o.func <= op_q;
      cell_o.res  <= (op_q == fxalu_pkg::OP_MUL) ? rnd[31:0] : res_q;
      cell_o.cmp  <= cmp_q;
      cell_o.dz   <= dz_q;
      cell_o.qneg <= qneg_q;
      cell_o.dvd  <= dvd_q;
      cell_o.rem  <= '0;
      cell_o.dvs  <= dvs_q;
      cell_o.quo  <= '0;
    end
  end

endmodule

FILE: sv/fxalu_cell.sv
module fxalu_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  fxalu_pkg::cell_t       cell_i,
  output logic                   valid_o,
  output fxalu_pkg::cell_t       cell_o
);

  localparam int unsigned RemW = fxalu_pkg::RemW;
  localparam int unsigned DivW = fxalu_pkg::DivW;

  logic [RemW:0]   rsh;
  logic [RemW+1:0] diff;
  logic            ge;
  fxalu_pkg::cell_t cell_d;

  always_comb begin
    rsh    = {cell_i.rem, cell_i.dvd[DivW-1]};
    diff   = {1'b0, rsh} - {2'b00, cell_i.dvs};
    ge     = ~diff[RemW+1];
    cell_d = cell_i;
    cell_d.rem = ge ? diff[RemW-1:0] : rsh[RemW-1:0];
    cell_d.dvd = {cell_i.dvd[DivW-2:0], 1'b0};
    cell_d.quo = {cell_i.quo[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_o <= cell_d;
    end
  end

endmodule

FILE: sv/fixed_point_alu_q24_8_top.sv
// channel | dir | payload
// in_i    | in  | func, operand_a, operand_b
// out_o   | out | result_value, compare_true, divide_by_zero
//
// One beat per cycle while out_o is not stalled; two front stages, then one cell per
// dividend bit (41) for the divide chain, then the output register.
// Reset clears only the valid bits; the whole chain holds while a result waits.
module fixed_point_alu_q24_8_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  fxalu_in_if.sink    in_i,
  fxalu_out_if.source out_o
);

  localparam int unsigned DivW = fxalu_pkg::DivW;

  logic             en;
  logic             v [DivW+1];
  fxalu_pkg::cell_t c [DivW+1];
  logic [31:0]      res;

  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  fxalu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .func_i  (in_i.func),
    .a_i     (in_i.operand_a),
    .b_i     (in_i.operand_b),
    .valid_o (v[0]),
    .cell_o  (c[0])
  );

  for (genvar i = 0; i < DivW; i++) begin : g_cell
    fxalu_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v[i]),
      .cell_i  (c[i]),
      .valid_o (v[i+1]),
      .cell_o  (c[i+1])
    );
  end

  always_comb begin
    if (c[DivW].func == fxalu_pkg::OP_DIV) begin
      res = c[DivW].dz ? 32'd0 : (c[DivW].qneg ? ~c[DivW].quo : c[DivW].quo);
    end else begin
      res = c[DivW].res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_o.valid <= 1'b0;
    end else if (en) begin
      out_o.valid <= v[DivW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_o.result_value   <= res;
      out_o.compare_true   <= c[DivW].cmp;
      out_o.divide_by_zero <= c[DivW].dz;
    end
  end

endmodule

FILE: test/tb_fixed_point_alu_q24_8_top.sv
module tb_fixed_point_alu_q24_8_top;

  typedef struct {
    fxalu_pkg::op_e     func;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_op_t;

  typedef struct {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  fxalu_in_if  in_bus ();
  fxalu_out_if out_bus ();

  fixed_point_alu_q24_8_top i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus.sink),
    .out_o (out_bus.source)
  );

  always #6 clk_i = ~clk_i;

  alu_op_t     op_queue[$];
  alu_result_t result_queue[$];
  int          error_count = 0;
  int          beats_out = 0;
  bit          in_beat = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic longint floor_quot(input longint x, input longint d);
    longint q;
    q = x / d;
    if ((x % d) != 0 && x < 0) begin
      q--;
    end
    return q;
  endfunction

  function automatic alu_result_t predict_alu(input alu_op_t op);
    alu_result_t r;
    longint a;
    longint b;
    longint n;
    longint d;
    longint scale;
    longint half;
    a = longint'(op.a);
    b = longint'(op.b);
    scale = longint'(1) << fxalu_pkg::FracBits;
    half = longint'(1) << (fxalu_pkg::FracBits - 1);
    r.value = '0;
    r.cmp = 1'b0;
    r.dz = 1'b0;
    case (op.func)
      fxalu_pkg::OP_ADD:  r.value = 32'(a + b);
      fxalu_pkg::OP_SUB:  r.value = 32'(a - b);
      fxalu_pkg::OP_MUL:  r.value = 32'(floor_quot(a * b + half - 1, scale));
      fxalu_pkg::OP_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          n = a * scale;
          d = b;
          if (d < 0) begin
            n = -n;
            d = -d;
          end
          r.value = 32'(floor_quot(2 * n + d - 1, 2 * d));
        end
      end
      fxalu_pkg::OP_GT:   r.cmp = a > b;
      fxalu_pkg::OP_LT:   r.cmp = a < b;
      fxalu_pkg::OP_GE:   r.cmp = a >= b;
      fxalu_pkg::OP_LE:   r.cmp = a <= b;
      fxalu_pkg::OP_EQ:   r.cmp = a == b;
      fxalu_pkg::OP_NE:   r.cmp = a != b;
      fxalu_pkg::OP_MIN:  r.value = 32'((a < b) ? a : b);
      fxalu_pkg::OP_MAX:  r.value = 32'((a > b) ? a : b);
      fxalu_pkg::OP_INC:  r.value = 32'(a + 1);
      fxalu_pkg::OP_DEC:  r.value = 32'(a - 1);
      fxalu_pkg::OP_TOI:  r.value = 32'(floor_quot(a, scale));
      default:            r.value = 32'(a * scale);
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fffffff - $urandom_range(0, 3);
      1:       return 32'sh80000000 + $urandom_range(0, 3);
      2:       return $signed($urandom_range(0, 4096)) - 2048;
      3:       return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_op(input fxalu_pkg::op_e f, input logic [31:0] a, input logic [31:0] b);
    alu_op_t op;
    op.func = f;
    op.a = a;
    op.b = b;
    op_queue.push_back(op);
  endtask

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    add_op(fxalu_pkg::OP_ADD, 32'h7fffffff, 32'h00000001);
    add_op(fxalu_pkg::OP_SUB, 32'h80000000, 32'h00000001);
    add_op(fxalu_pkg::OP_MUL, 32'h00000001, 32'h00000080);
    add_op(fxalu_pkg::OP_MUL, 32'hffffffff, 32'h00000080);
    add_op(fxalu_pkg::OP_MUL, 32'h80000000, 32'h80000000);
    add_op(fxalu_pkg::OP_MUL, 32'h7fffffff, 32'h7fffffff);
    add_op(fxalu_pkg::OP_DIV, 32'h00000001, 32'h00000200);
    add_op(fxalu_pkg::OP_DIV, 32'hffffffff, 32'h00000200);
    add_op(fxalu_pkg::OP_DIV, 32'h80000000, 32'hffffffff);
    add_op(fxalu_pkg::OP_DIV, 32'h12345678, 32'h00000000);
    add_op(fxalu_pkg::OP_DIV, 32'h7fffffff, 32'h80000000);
    add_op(fxalu_pkg::OP_GT, 32'h80000000, 32'h7fffffff);
    add_op(fxalu_pkg::OP_LT, 32'h80000000, 32'h7fffffff);
    add_op(fxalu_pkg::OP_GE, 32'h00000005, 32'h00000005);
    add_op(fxalu_pkg::OP_LE, 32'h00000005, 32'h00000005);
    add_op(fxalu_pkg::OP_EQ, 32'hffffffff, 32'hffffffff);
    add_op(fxalu_pkg::OP_NE, 32'hffffffff, 32'hffffffff);
    add_op(fxalu_pkg::OP_MIN, 32'h00000300, 32'h00000300);
    add_op(fxalu_pkg::OP_MAX, 32'h80000000, 32'h7fffffff);
    add_op(fxalu_pkg::OP_INC, 32'h7fffffff, 32'h00000000);
    add_op(fxalu_pkg::OP_DEC, 32'h80000000, 32'hffffffff);
    add_op(fxalu_pkg::OP_TOI, 32'hffffff01, 32'h00000000);
    add_op(fxalu_pkg::OP_TOI, 32'h7fffffff, 32'h00000000);
    add_op(fxalu_pkg::OP_FROM, 32'h00800000, 32'h00000000);
    add_op(fxalu_pkg::OP_FROM, 32'h80000000, 32'h00000000);
    repeat (1450) begin
      a = pick_operand();
      b = ($urandom_range(0, 15) == 0) ? a : pick_operand();
      if ($urandom_range(0, 20) == 0) begin
        b = '0;
      end
      add_op(fxalu_pkg::op_e'($urandom_range(0, 15)), a, b);
    end
  end

  int gap_left = 0;
  int burst_left = 0;

  initial begin
    in_bus.valid = 1'b0;
    in_bus.func = '0;
    in_bus.operand_a = '0;
    in_bus.operand_b = '0;
    out_bus.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    alu_op_t op;
    if (rst_ni && (!in_bus.valid || in_beat)) begin
      if (gap_left > 0 || op_queue.size() == 0) begin
        in_bus.valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end
      end else begin
        op = op_queue.pop_front();
        in_bus.valid <= 1'b1;
        in_bus.func <= op.func;
        in_bus.operand_a <= op.a;
        in_bus.operand_b <= op.b;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  int holdoff = 0;
  bit holdoff_done = 1'b0;
  int stall_phase = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!holdoff_done && beats_out >= 300) begin
        holdoff_done = 1'b1;
        holdoff = 400;
      end
      stall_phase = (stall_phase + 1) % 256;
      if (holdoff > 0) begin
        holdoff--;
        out_bus.ready <= 1'b0;
      end else if (stall_phase < 64) begin
        out_bus.ready <= 1'b1;
      end else if (stall_phase < 128) begin
        out_bus.ready <= stall_phase[2];
      end else begin
        out_bus.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk_i) begin
    alu_op_t op;
    alu_result_t want;
    in_beat = in_bus.valid && in_bus.ready;
    if (in_beat) begin
      op.func = fxalu_pkg::op_e'(in_bus.func);
      op.a = in_bus.operand_a;
      op.b = in_bus.operand_b;
      result_queue.push_back(predict_alu(op));
    end
    if (out_bus.valid && out_bus.ready) begin
      beats_out++;
      if (result_queue.size() == 0) begin
        report($sformatf("unexpected result beat %0d", beats_out));
      end else begin
        want = result_queue.pop_front();
        if (out_bus.result_value !== want.value) begin
          report($sformatf("beat %0d value %h, want %h", beats_out,
                           out_bus.result_value, want.value));
        end
        if (out_bus.compare_true !== want.cmp) begin
          report($sformatf("beat %0d compare %b, want %b", beats_out,
                           out_bus.compare_true, want.cmp));
        end
        if (out_bus.divide_by_zero !== want.dz) begin
          report($sformatf("beat %0d div-by-zero %b, want %b", beats_out,
                           out_bus.divide_by_zero, want.dz));
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (op_queue.size() == 0);
    while (in_bus.valid || result_queue.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (60) @(posedge clk_i);
    if (result_queue.size() != 0) begin
      report("results still outstanding");
    end
    if (error_count == 0) begin
      $display("** fixed_point_alu_q24_8_top: PASSED **");
    end else begin
      $display("** fixed_point_alu_q24_8_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("** fixed_point_alu_q24_8_top: FAILED **");
    $finish;
  end
endmodule
